[src/token_line_indenter_macros.svh]
// assertion helpers for token_line_indenter.sv
`ifndef TOKEN_LINE_INDENTER_MACROS_SVH
`define TOKEN_LINE_INDENTER_MACROS_SVH

// checked on every rising edge outside reset
`define TLI_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// implication checked on every rising edge outside reset
`define TLI_ASSERT_IMP(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

`endif

[src/tli_pkg.sv]
`timescale 1ns / 1ps
package tli_pkg;

  localparam logic [3:0] K_OTHER   = 4'd0;
  localparam logic [3:0] K_BOPEN   = 4'd1;
  localparam logic [3:0] K_BCLOSE  = 4'd2;
  localparam logic [3:0] K_SEMI    = 4'd3;
  localparam logic [3:0] K_COLON   = 4'd4;
  localparam logic [3:0] K_COMMA   = 4'd5;
  localparam logic [3:0] K_POPEN   = 4'd6;
  localparam logic [3:0] K_PCLOSE  = 4'd7;
  localparam logic [3:0] K_PPRESET = 4'd8;
  localparam logic [3:0] K_DEFINE  = 4'd9;
  localparam logic [3:0] K_ACCESS  = 4'd10;
  localparam logic [3:0] K_SWITCH  = 4'd11;
  localparam logic [3:0] K_CASE    = 4'd12;
  localparam logic [3:0] K_IDENT   = 4'd13;
  localparam logic [3:0] K_COMMENT = 4'd14;
  localparam logic [3:0] K_INVALID = 4'd15;

  // prior line end: bit 4 set means no line counted yet
  localparam logic [4:0] PRIOR_NONE = 5'd16;

  localparam logic CFG_TAB_WIDTH    = 1'b0;
  localparam logic CFG_START_INDENT = 1'b1;

  typedef struct packed {
    logic [3:0]  token_kind;
    logic [23:0] char_pos;
    logic [11:0] line_advance;
    logic        in_define_body;
    logic        in_directive;
    logic        label_follows;
    logic        end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [11:0] indent;
    logic [12:0] line_count;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic signed [12:0] indent;
    logic [15:0]        brace;
  } switch_entry_t;

  function automatic logic signed [26:0] sx13(logic signed [12:0] v);
    return {{14{v[12]}}, v};
  endfunction

  function automatic logic signed [12:0] sat13(logic signed [26:0] v);
    if (v < -27'sd4096) return -13'sd4096;
    if (v > 27'sd4095) return 13'sd4095;
    return v[12:0];
  endfunction

  function automatic logic [11:0] clamp_out(logic signed [12:0] v);
    return v[12] ? 12'd0 : v[11:0];
  endfunction

endpackage

[src/token_line_indenter.sv]
`timescale 1ns / 1ps
// channel | dir | handshake            | payload
// in      | in  | in_valid_i/in_ready_o | in_item_i  (tli_pkg::in_item_t)
// out     | out | out_valid_o/out_ready_i | out_item_o (tli_pkg::out_item_t)
// cfg     | in  | cfg_we_i               | cfg_idx_i, cfg_data_i
// one item per cycle while in_ready_o; state updates in the accepting cycle
// stack tops in registers, lower entries in two registered-read memories;
// a pop fetches the new top during the next cycle without stalling
// results go to a 4-entry output queue; in_ready_o drops when fewer than two
// slots are free, so items with two results sustain one result per cycle
// no clearing pass after reset; stack memories need no init
`include "token_line_indenter_macros.svh"
module token_line_indenter #(
  parameter int SW_STACK_DEPTH  = 16,
  parameter int PAR_STACK_DEPTH = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  tli_pkg::in_item_t    in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output tli_pkg::out_item_t   out_item_o,
  input  logic                 cfg_we_i,
  input  logic                 cfg_idx_i,
  input  logic [11:0]          cfg_data_i
);
  import tli_pkg::*;

  localparam int SCW = $clog2(SW_STACK_DEPTH + 1);
  localparam int PCW = $clog2(PAR_STACK_DEPTH + 1);
  localparam int SAW = (SW_STACK_DEPTH > 1) ? $clog2(SW_STACK_DEPTH) : 1;
  localparam int PAW = (PAR_STACK_DEPTH > 1) ? $clog2(PAR_STACK_DEPTH) : 1;

  // state registers
  logic [4:0]         tab_q;
  logic signed [12:0] cur_q, nxt_q, cur_d, nxt_d;
  logic               def_q, def_d;
  logic [11:0]        ibd_q, ibd_d;
  logic [15:0]        bd_q, bd_d;
  logic [SCW-1:0]     sc_q, sc_d;
  logic [PCW-1:0]     pc_q, pc_d;
  logic [4:0]         prior_q, prior_d;
  logic [3:0]         lfk_q, lfk_d, llk_q, llk_d;
  logic [23:0]        lfp_q, lfp_d;
  logic               lls_q, lls_d, lopen_q, lopen_d;

  // stack tops and refill
  logic signed [12:0] ptop_q, ptop_d, ptop_eff;
  switch_entry_t      stop_q, stop_d, stop_eff;
  logic               prefill_q, prefill_d, srefill_q, srefill_d;

  // memories
  logic signed [12:0] pmem [PAR_STACK_DEPTH];
  switch_entry_t      smem [SW_STACK_DEPTH];
  logic signed [12:0] prdata_q;
  switch_entry_t      srdata_q;
  logic               pw_en, sw_en;
  logic [PAW-1:0]     pw_addr, p_raddr;
  logic [SAW-1:0]     sw_addr, s_raddr;
  logic signed [12:0] pw_data;
  switch_entry_t      sw_data;

  // output queue
  out_item_t fifo_q [4];
  logic [1:0] wp_q, rp_q;
  logic [2:0] fcnt_q;
  logic       push0, push1;
  out_item_t  res0, res1;

  logic in_acc, out_acc;
  assign in_ready_o  = (fcnt_q <= 3'd2);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_valid_o = (fcnt_q != 3'd0);
  assign out_acc     = out_valid_o && out_ready_i;
  assign out_item_o  = fifo_q[rp_q];

  assign ptop_eff = prefill_q ? prdata_q : ptop_q;
  assign stop_eff = srefill_q ? srdata_q : stop_q;

  always_comb begin
    logic [3:0]         kind;
    logic               closed, complete, do_close;
    logic signed [12:0] r, cur, nxt, ptop;
    logic [PCW-1:0]     pc_m2;
    logic [SCW-1:0]     sc_m2;
    logic [PCW-1:0]     pc_m1;
    logic [SCW-1:0]     sc_m1;
    kind = (in_item_i.token_kind == K_INVALID) ? K_OTHER : in_item_i.token_kind;
    cur = cur_q; nxt = nxt_q; def_d = def_q; ibd_d = ibd_q; bd_d = bd_q;
    sc_d = sc_q; pc_d = pc_q; prior_d = prior_q; lfk_d = lfk_q; lfp_d = lfp_q;
    llk_d = llk_q; lls_d = lls_q; lopen_d = lopen_q;
    ptop = ptop_eff; stop_d = stop_eff;
    prefill_d = 1'b0; srefill_d = 1'b0;
    pw_en = 1'b0; sw_en = 1'b0;
    pc_m1 = pc_q - PCW'(1); sc_m1 = sc_q - SCW'(1);
    pc_m2 = pc_q - PCW'(2); sc_m2 = sc_q - SCW'(2);
    pw_addr = pc_m1[PAW-1:0]; pw_data = ptop_eff;
    sw_addr = sc_m1[SAW-1:0]; sw_data = stop_eff;
    p_raddr = pc_m2[PAW-1:0]; s_raddr = sc_m2[SAW-1:0];
    push0 = 1'b0; push1 = 1'b0;
    res0 = '0; res1 = '0;
    closed = 1'b0; complete = 1'b0; r = '0;

    do_close = in_acc && lopen_q &&
               (in_item_i.end_of_text || (in_item_i.line_advance != 12'd0));
    if (do_close) begin
      if (llk_q == K_POPEN && pc_q != '0) ptop = sat13(sx13(cur) + 27'(tab_q));
      if (!lls_q) prior_d = {1'b0, llk_q};
      if (nxt[12]) nxt = '0;
      if (cur[12]) cur = '0;
      if (def_q) begin
        cur = sat13(sx13(cur) + 27'(tab_q));
      end else if (lfk_q == K_DEFINE) begin
        ibd_d = cur[11:0];
        cur = '0;
        nxt = '0;
        def_d = 1'b1;
      end
      r = cur;
      cur = nxt;
      lopen_d = 1'b0;
      closed = 1'b1;
      push0 = 1'b1;
      res0.indent = clamp_out(r);
      res0.line_count = 13'd1;
      res0.last = 1'b1;
    end

    if (in_acc && !in_item_i.end_of_text) begin
      if (!lopen_d) begin
        if (def_d && (!in_item_i.in_define_body || kind == K_DEFINE)) begin
          def_d = 1'b0;
          cur = {1'b0, ibd_d};
        end
        if (prior_d != PRIOR_NONE) begin
          complete = (prior_d == {1'b0, K_BOPEN}) || (prior_d == {1'b0, K_BCLOSE}) ||
                     (prior_d == {1'b0, K_SEMI}) || (prior_d == {1'b0, K_COLON}) ||
                     (prior_d == {1'b0, K_COMMA});
          if (!complete) cur = sat13(sx13(cur) + 27'(tab_q));
        end
        if (pc_q != '0) cur = ptop;
        if (closed && in_item_i.line_advance > 12'd1) begin
          res0.last = 1'b0;
          push1 = 1'b1;
          res1.indent = clamp_out(cur);
          res1.line_count = {1'b0, in_item_i.line_advance} - 13'd1;
          res1.last = 1'b1;
        end
        unique case (kind)
          K_PPRESET: cur = '0;
          K_BOPEN: if (!complete && pc_q == '0) cur = sat13(sx13(cur) - 27'(tab_q));
          K_BCLOSE, K_ACCESS: cur = sat13(sx13(cur) - 27'(tab_q));
          K_SWITCH: begin
            if (sc_q < SCW'(SW_STACK_DEPTH)) begin
              sw_en = (sc_q != '0);
              stop_d.indent = cur;
              stop_d.brace = bd_q;
              sc_d = sc_q + SCW'(1);
            end
          end
          K_CASE: begin
            if (sc_q != '0) cur = stop_eff.indent;
            nxt = sat13(sx13(cur) + 27'(tab_q));
          end
          K_IDENT: if (in_item_i.label_follows) cur = '0;
          default: ;
        endcase
        lfk_d = kind;
        lfp_d = in_item_i.char_pos;
        lopen_d = 1'b1;
      end

      unique case (kind)
        K_BCLOSE: begin
          bd_d = bd_q - 16'd1;
          nxt = sat13(sx13(nxt) - 27'(tab_q));
          if (sc_d != '0 && stop_d.brace == bd_d) begin
            sc_d = sc_d - SCW'(1);
            srefill_d = (sc_d != '0);
          end
        end
        K_BOPEN: begin
          nxt = sat13(sx13(nxt) + 27'(tab_q));
          if (pc_q != '0) ptop = sat13(sx13(ptop) + 27'(tab_q));
          bd_d = bd_q + 16'd1;
        end
        K_POPEN: begin
          if (pc_q < PCW'(PAR_STACK_DEPTH)) begin
            pw_en = (pc_q != '0);
            pw_data = ptop;
            ptop = sat13(27'({3'b0, in_item_i.char_pos}) - 27'({3'b0, lfp_d})
                         + sx13(cur) + 27'sd1);
            pc_d = pc_q + PCW'(1);
          end
        end
        K_PCLOSE: begin
          if (pc_q != '0) begin
            pc_d = pc_m1;
            prefill_d = (pc_m1 != '0);
          end
        end
        default: ;
      endcase
      llk_d = kind;
      lls_d = in_item_i.in_directive || in_item_i.in_define_body || kind == K_COMMENT;
    end
    cur_d = cur;
    nxt_d = nxt;
    ptop_d = ptop;
  end

  always_ff @(posedge clk_i) begin
    if (pw_en) pmem[pw_addr] <= pw_data;
    if (sw_en) smem[sw_addr] <= sw_data;
    prdata_q <= pmem[p_raddr];
    srdata_q <= smem[s_raddr];
    ptop_q <= ptop_d;
    stop_q <= stop_d;
    if (push0) fifo_q[wp_q] <= res0;
    if (push1) fifo_q[wp_q + 2'd1] <= res1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tab_q <= 5'd4; cur_q <= '0; nxt_q <= '0; def_q <= 1'b0; ibd_q <= '0;
      bd_q <= '0; sc_q <= '0; pc_q <= '0; prior_q <= PRIOR_NONE;
      lfk_q <= K_OTHER; lfp_q <= '0; llk_q <= K_OTHER; lls_q <= 1'b0; lopen_q <= 1'b0;
      prefill_q <= 1'b0; srefill_q <= 1'b0;
      wp_q <= '0; rp_q <= '0; fcnt_q <= '0;
    end else begin
      def_q <= def_d; ibd_q <= ibd_d; bd_q <= bd_d; sc_q <= sc_d; pc_q <= pc_d;
      prior_q <= prior_d; lfk_q <= lfk_d; lfp_q <= lfp_d; llk_q <= llk_d;
      lls_q <= lls_d; lopen_q <= lopen_d;
      prefill_q <= prefill_d; srefill_q <= srefill_d;
      if (cfg_we_i && cfg_idx_i == CFG_START_INDENT) begin
        cur_q <= {1'b0, cfg_data_i};
        nxt_q <= {1'b0, cfg_data_i};
      end else begin
        cur_q <= cur_d;
        nxt_q <= nxt_d;
      end
      if (cfg_we_i && cfg_idx_i == CFG_TAB_WIDTH) tab_q <= cfg_data_i[4:0];
      wp_q <= wp_q + {1'b0, push0} + {1'b0, push1};
      if (out_acc) rp_q <= rp_q + 2'd1;
      fcnt_q <= fcnt_q + {2'b0, push0} + {2'b0, push1} - {2'b0, out_acc};
    end
  end

  `TLI_ASSERT(a_fifo_bound, fcnt_q <= 3'd4, "output queue overflow")
  `TLI_ASSERT_IMP(a_prefill, prefill_q, pc_q != '0, "paren refill with empty stack")
  `TLI_ASSERT_IMP(a_srefill, srefill_q, sc_q != '0, "switch refill with empty stack")
  `TLI_ASSERT_IMP(a_run_pair, push1, push0 && !res0.last, "run result without closed line")

endmodule
